// ===== sv/ille_pkg.sv =====
package ille_pkg;

   localparam int CAPACITY   = 64;
   localparam int DATA_WIDTH = 32;
   localparam int IW         = $clog2(CAPACITY + 1);

   localparam logic [IW-1:0] HEAD_ID = IW'(0);

   // Command codes.
   localparam logic [2:0] CMD_INS_FRONT = 3'd0;
   localparam logic [2:0] CMD_INS_POS   = 3'd1;
   localparam logic [2:0] CMD_DEL_POS   = 3'd2;
   localparam logic [2:0] CMD_INS_SLOT  = 3'd3;
   localparam logic [2:0] CMD_DEL_SLOT  = 3'd4;

   // Status codes.
   localparam logic [2:0] ST_OK   = 3'd0;
   localparam logic [2:0] ST_FULL = 3'd1;
   localparam logic [2:0] ST_POS  = 3'd2;
   localparam logic [2:0] ST_SENT = 3'd3;
   localparam logic [2:0] ST_SLOT = 3'd4;

   // Datapath micro-operations.
   localparam logic [4:0] OP_IDLE  = 5'd0;
   localparam logic [4:0] OP_CLR   = 5'd1;
   localparam logic [4:0] OP_LATCH = 5'd2;
   localparam logic [4:0] OP_DEC   = 5'd3;
   localparam logic [4:0] OP_W0    = 5'd4;
   localparam logic [4:0] OP_W1    = 5'd5;
   localparam logic [4:0] OP_WEND  = 5'd6;
   localparam logic [4:0] OP_D1    = 5'd7;
   localparam logic [4:0] OP_TF0   = 5'd8;
   localparam logic [4:0] OP_TF1   = 5'd9;
   localparam logic [4:0] OP_TS0   = 5'd10;
   localparam logic [4:0] OP_TS1   = 5'd11;
   localparam logic [4:0] OP_ENG   = 5'd12;
   localparam logic [4:0] OP_AT    = 5'd13;
   localparam logic [4:0] OP_LA0   = 5'd14;
   localparam logic [4:0] OP_LA1   = 5'd15;
   localparam logic [4:0] OP_LA2   = 5'd16;
   localparam logic [4:0] OP_VR0   = 5'd17;
   localparam logic [4:0] OP_VR1   = 5'd18;
   localparam logic [4:0] OP_UL0   = 5'd19;
   localparam logic [4:0] OP_UL1   = 5'd20;
   localparam logic [4:0] OP_FREE  = 5'd21;
   localparam logic [4:0] OP_FP0   = 5'd22;
   localparam logic [4:0] OP_FP1   = 5'd23;
   localparam logic [4:0] OP_FIN   = 5'd24;

   // Routes chosen at decode.
   localparam logic [2:0] RT_ERR    = 3'd0;
   localparam logic [2:0] RT_TF     = 3'd1;
   localparam logic [2:0] RT_TS     = 3'd2;
   localparam logic [2:0] RT_WALK   = 3'd3;
   localparam logic [2:0] RT_VREAD  = 3'd4;
   localparam logic [2:0] RT_UNLINK = 3'd5;

   // Where a new node is linked in.
   localparam logic [1:0] MODE_KEEP = 2'd0;
   localparam logic [1:0] MODE_HEAD = 2'd1;
   localparam logic [1:0] MODE_TAIL = 2'd2;

   typedef struct packed {
      logic [2:0]            cmd;
      logic [6:0]            position;
      logic [6:0]            slot;
      logic [DATA_WIDTH-1:0] value;
   } req_type;

   typedef struct packed {
      logic [2:0] status;
      logic [6:0] slot_used;
      logic [6:0] count;
   } rsp_type;

   typedef struct packed {
      logic [4:0] op;
      logic       fin;
   } ctl_type;

   typedef struct packed {
      logic [2:0] route;
      logic       single;
      logic       pos_zero;
      logic       k_one;
      logic       cur_zero;
      logic       fh_zero;
      logic       clr_last;
      logic       is_del;
   } sts_type;

endpackage

// ===== sv/ille_datapath.sv =====
module ille_datapath (
   input  logic             clock,
   input  logic             reset,
   input  ille_pkg::req_type req_data,
   input  ille_pkg::ctl_type ctl,
   output ille_pkg::sts_type sts,
   output ille_pkg::rsp_type rsp_data
);
   import ille_pkg::*;

   logic [IW-1:0]         next_mem [0:CAPACITY];
   logic [IW-1:0]         prev_mem [0:CAPACITY];
   logic [DATA_WIDTH-1:0] val_mem  [0:CAPACITY];

   logic [2:0]            cmd_ff;
   logic [IW-1:0]         pos_ff, slot_ff;
   logic [DATA_WIDTH-1:0] val_ff, x_ff, vq_ff;
   logic [IW-1:0]         fh_ff, cnt_ff, cur_ff, k_ff, e_ff, at_ff, old_ff, used_ff, clr_ff;
   logic [IW-1:0]         nq_ff, pq_ff;
   logic [CAPACITY:0]     eng_ff;
   logic [1:0]            mode_ff;
   logic [2:0]            status_ff;

   logic [IW-1:0]         rd_addr;
   logic                  nwe, pwe, vwe;
   logic [IW-1:0]         nwa, nwd, pwa, pwd, vwa;
   logic [DATA_WIDTH-1:0] vwd;

   logic                  full, slot_big, slot_eng;
   logic [2:0]            dec_status, dec_route;
   logic [1:0]            dec_mode;

   // Decode of the latched request against the current list state.
   always_comb begin
      full       = cnt_ff >= IW'(CAPACITY);
      slot_big   = slot_ff > IW'(CAPACITY);
      slot_eng   = !slot_big && eng_ff[slot_ff];
      dec_status = ST_OK;
      dec_route  = RT_ERR;
      dec_mode   = MODE_KEEP;
      unique case (cmd_ff)
         CMD_INS_FRONT: begin
            if (full) dec_status = ST_FULL;
            else begin
               dec_route = RT_TF;
               dec_mode  = MODE_HEAD;
            end
         end
         CMD_INS_POS: begin
            if (full) dec_status = ST_FULL;
            else if ({1'b0, pos_ff} > ({1'b0, cnt_ff} + (IW+1)'(1))) dec_status = ST_POS;
            else dec_route = RT_WALK;
         end
         CMD_DEL_POS: begin
            if (pos_ff > cnt_ff) dec_status = ST_POS;
            else dec_route = RT_WALK;
         end
         CMD_INS_SLOT: begin
            if (slot_ff == HEAD_ID) dec_status = ST_SENT;
            else if (slot_big) dec_status = ST_SLOT;
            else if (!slot_eng) begin
               dec_route = RT_TS;
               dec_mode  = MODE_TAIL;
            end else if (full) dec_status = ST_FULL;
            else begin
               dec_route = RT_VREAD;
               dec_mode  = MODE_HEAD;
            end
         end
         CMD_DEL_SLOT: begin
            if (slot_ff == HEAD_ID) dec_status = ST_SENT;
            else if (!slot_eng) dec_status = ST_SLOT;
            else dec_route = RT_UNLINK;
         end
         default: dec_status = ST_POS;
      endcase
   end

   always_comb begin
      sts.route    = dec_route;
      sts.single   = nq_ff == fh_ff;
      sts.pos_zero = pos_ff == IW'(0);
      sts.k_one    = k_ff == IW'(1);
      sts.cur_zero = cur_ff == HEAD_ID;
      sts.fh_zero  = fh_ff == HEAD_ID;
      sts.clr_last = clr_ff == IW'(CAPACITY);
      sts.is_del   = cmd_ff == CMD_DEL_POS;
   end

   // Link memory read address.
   always_comb begin
      unique case (ctl.op)
         OP_W0, OP_ENG:  rd_addr = HEAD_ID;
         OP_W1, OP_TF1:  rd_addr = nq_ff;
         OP_WEND:        rd_addr = cur_ff;
         OP_TF0, OP_FP0: rd_addr = fh_ff;
         OP_LA0:         rd_addr = at_ff;
         default:        rd_addr = e_ff;
      endcase
   end

   // Memory write ports.
   always_comb begin
      nwe = 1'b0; nwa = e_ff; nwd = e_ff;
      pwe = 1'b0; pwa = e_ff; pwd = e_ff;
      vwe = 1'b0; vwa = e_ff; vwd = x_ff;
      unique case (ctl.op)
         OP_CLR: begin
            nwe = 1'b1; nwa = clr_ff;
            pwe = 1'b1; pwa = clr_ff;
            if (clr_ff == HEAD_ID) begin
               nwd = HEAD_ID;
               pwd = HEAD_ID;
            end else begin
               nwd = (clr_ff == IW'(CAPACITY)) ? IW'(1) : clr_ff + IW'(1);
               pwd = (clr_ff == IW'(1)) ? IW'(CAPACITY) : clr_ff - IW'(1);
            end
         end
         OP_TS1, OP_UL1: begin
            if (ctl.op == OP_UL1 || nq_ff != e_ff) begin
               nwe = 1'b1; nwa = pq_ff; nwd = nq_ff;
               pwe = 1'b1; pwa = nq_ff; pwd = pq_ff;
            end
         end
         OP_LA1: begin
            nwe = 1'b1; nwa = at_ff; nwd = e_ff;
            pwe = 1'b1; pwa = e_ff;  pwd = at_ff;
         end
         OP_LA2: begin
            nwe = 1'b1; nwa = e_ff;   nwd = old_ff;
            pwe = 1'b1; pwa = old_ff; pwd = e_ff;
         end
         OP_FP0: begin
            if (fh_ff == HEAD_ID) begin
               nwe = 1'b1;
               pwe = 1'b1;
            end
         end
         OP_ENG: vwe = 1'b1;
         OP_VR1: begin
            vwe = 1'b1; vwa = slot_ff; vwd = val_ff;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (nwe) next_mem[nwa] <= nwd;
      if (pwe) prev_mem[pwa] <= pwd;
      if (vwe) val_mem[vwa] <= vwd;
      nq_ff <= next_mem[rd_addr];
      pq_ff <= prev_mem[rd_addr];
      vq_ff <= val_mem[slot_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fh_ff  <= IW'(1);
         cnt_ff <= '0;
         eng_ff <= '0;
         clr_ff <= '0;
      end else begin
         unique case (ctl.op)
            OP_CLR: clr_ff <= clr_ff + IW'(1);
            OP_LATCH: begin
               cmd_ff  <= req_data.cmd;
               pos_ff  <= req_data.position;
               slot_ff <= req_data.slot;
               val_ff  <= req_data.value;
            end
            OP_DEC: begin
               status_ff <= dec_status;
               used_ff   <= '0;
               e_ff      <= slot_ff;
               x_ff      <= val_ff;
               mode_ff   <= dec_mode;
            end
            OP_W0: begin
               cur_ff <= HEAD_ID;
               k_ff   <= pos_ff;
            end
            OP_W1: begin
               cur_ff <= nq_ff;
               k_ff   <= k_ff - IW'(1);
            end
            OP_WEND: begin
               e_ff <= cur_ff;
               if (cmd_ff == CMD_DEL_POS && cur_ff == HEAD_ID) status_ff <= ST_SENT;
            end
            OP_D1, OP_FP1: at_ff <= pq_ff;
            OP_TF1: begin
               if (nq_ff == fh_ff) begin
                  e_ff  <= fh_ff;
                  fh_ff <= HEAD_ID;
               end else e_ff <= nq_ff;
            end
            OP_TS1: begin
               if (nq_ff == e_ff) fh_ff <= HEAD_ID;
               else if (e_ff == fh_ff) fh_ff <= nq_ff;
            end
            OP_ENG: begin
               eng_ff[e_ff] <= 1'b1;
               cnt_ff       <= cnt_ff + IW'(1);
               used_ff      <= e_ff;
            end
            OP_AT: begin
               if (mode_ff == MODE_HEAD) at_ff <= HEAD_ID;
               else if (mode_ff == MODE_TAIL) at_ff <= pq_ff;
            end
            OP_LA1: old_ff <= nq_ff;
            OP_VR1: x_ff <= vq_ff;
            OP_FREE: begin
               eng_ff[e_ff] <= 1'b0;
               cnt_ff       <= cnt_ff - IW'(1);
               used_ff      <= e_ff;
            end
            OP_FP0: if (fh_ff == HEAD_ID) fh_ff <= e_ff;
            default: ;
         endcase
      end
   end

   assign rsp_data.status    = status_ff;
   assign rsp_data.slot_used = used_ff;
   assign rsp_data.count     = cnt_ff;

endmodule

// ===== sv/ille_controller.sv =====
module ille_controller (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  ille_pkg::sts_type sts,
   output ille_pkg::ctl_type ctl,
   output logic              busy
);
   import ille_pkg::*;

   localparam logic [4:0] S_IDLE = OP_IDLE;
   localparam logic [4:0] S_CLR  = OP_CLR;
   localparam logic [4:0] S_DEC  = OP_DEC;
   localparam logic [4:0] S_W0   = OP_W0;
   localparam logic [4:0] S_W1   = OP_W1;
   localparam logic [4:0] S_WEND = OP_WEND;
   localparam logic [4:0] S_D1   = OP_D1;
   localparam logic [4:0] S_TF0  = OP_TF0;
   localparam logic [4:0] S_TF1  = OP_TF1;
   localparam logic [4:0] S_TS0  = OP_TS0;
   localparam logic [4:0] S_TS1  = OP_TS1;
   localparam logic [4:0] S_ENG  = OP_ENG;
   localparam logic [4:0] S_AT   = OP_AT;
   localparam logic [4:0] S_LA0  = OP_LA0;
   localparam logic [4:0] S_LA1  = OP_LA1;
   localparam logic [4:0] S_LA2  = OP_LA2;
   localparam logic [4:0] S_VR0  = OP_VR0;
   localparam logic [4:0] S_VR1  = OP_VR1;
   localparam logic [4:0] S_UL0  = OP_UL0;
   localparam logic [4:0] S_UL1  = OP_UL1;
   localparam logic [4:0] S_FREE = OP_FREE;
   localparam logic [4:0] S_FP0  = OP_FP0;
   localparam logic [4:0] S_FP1  = OP_FP1;
   localparam logic [4:0] S_FIN  = OP_FIN;

   logic [4:0] state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_CLR:  if (sts.clr_last) state_in = S_IDLE;
         S_IDLE: if (start) state_in = S_DEC;
         S_DEC: begin
            unique case (sts.route)
               RT_TF:     state_in = S_TF0;
               RT_TS:     state_in = S_TS0;
               RT_WALK:   state_in = S_W0;
               RT_VREAD:  state_in = S_VR0;
               RT_UNLINK: state_in = S_UL0;
               default:   state_in = S_FIN;
            endcase
         end
         S_W0:   state_in = sts.pos_zero ? S_WEND : S_W1;
         S_W1:   if (sts.k_one) state_in = S_WEND;
         S_WEND: begin
            if (!sts.is_del) state_in = S_D1;
            else if (sts.cur_zero) state_in = S_FIN;
            else state_in = S_UL0;
         end
         S_D1:   state_in = S_TF0;
         S_TF0:  state_in = S_TF1;
         S_TF1:  state_in = sts.single ? S_ENG : S_TS1;
         S_TS0:  state_in = S_TS1;
         S_TS1:  state_in = S_ENG;
         S_ENG:  state_in = S_AT;
         S_AT:   state_in = S_LA0;
         S_LA0:  state_in = S_LA1;
         S_LA1:  state_in = S_LA2;
         S_LA2:  state_in = S_FIN;
         S_VR0:  state_in = S_VR1;
         S_VR1:  state_in = S_TF0;
         S_UL0:  state_in = S_UL1;
         S_UL1:  state_in = S_FREE;
         S_FREE: state_in = S_FP0;
         S_FP0:  state_in = sts.fh_zero ? S_FIN : S_FP1;
         S_FP1:  state_in = S_LA0;
         S_FIN:  state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= S_CLR;
      else state_ff <= state_in;
   end

   assign ctl.op  = (state_ff == S_IDLE && start) ? OP_LATCH : state_ff;
   assign ctl.fin = state_ff == S_FIN;
   assign busy    = state_ff != S_IDLE;

endmodule

// ===== sv/indexed_linked_list_engine.sv =====
// A request refused at decode goes from decode straight to the response; front and slot
// commands run a short routine, and position commands first walk the list link by link;
// a walk covers at most 64 links.
// Requests: one at a time; busy stays high through the response cycle, so the next
// request can be taken in the cycle after it. The receiver cannot stall.
// Reset: the link memories are then rebuilt by a pass over all 65 slots, one slot per cycle, busy high.
module indexed_linked_list_engine (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  ille_pkg::req_type req_data,
   output logic              rsp_valid,
   output ille_pkg::rsp_type rsp_data
);
   import ille_pkg::*;

   // The controller sequences each request as a series of micro-operations: a decode that
   // rejects bad requests before any slot is taken, a walk that follows one next link per
   // cycle through the registered read of the link memory, and short routines that take a
   // slot from the free ring, splice a node in after another, or unlink a node and return it
   // to the free ring. The datapath holds the link and data memories and all list registers.
   ctl_type ctl;
   sts_type sts;

   ille_controller u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .sts   (sts),
      .ctl   (ctl),
      .busy  (busy)
   );

   ille_datapath u_dp (
      .clock    (clock),
      .reset    (reset),
      .req_data (req_data),
      .ctl      (ctl),
      .sts      (sts),
      .rsp_data (rsp_data)
   );

   // The result registers are stable throughout the final state, so the strobe alone marks it.
   assign rsp_valid = ctl.fin;

endmodule
